>>> src/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MIN_BLOCK_LOG2 = 4;
  localparam int HEAP_LOG2      = 20;

  localparam int REQ_W   = 32;
  localparam int OFF_W   = 20;
  localparam int GLVL_W  = 5;
  localparam int HEAP_W  = 21;
  localparam int HDR_W   = 7;
  localparam int TAG_W   = 5;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  localparam logic [HEAP_W-1:0] HEAP_RESET = 21'd1048576;
  localparam logic [HDR_W-1:0]  HDR_RESET  = 7'd24;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_FREED   = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic REG_HEAP = 1'b0;
  localparam logic REG_HDR  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [REQ_W-1:0]  request_bytes;
    logic [OFF_W-1:0]  block_offset;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [OFF_W-1:0]  granted_offset;
    logic [GLVL_W-1:0] granted_level;
  } out_t;

  typedef enum logic [3:0] {
    OP_CLR, OP_TOPW, OP_IDLE, OP_PREP, OP_SCAN_RD, OP_SCAN_CHK, OP_SPLIT_RD,
    OP_SPLIT_WR, OP_TAG, OP_FCHK1, OP_FCHK2, OP_MRD, OP_MCHK, OP_SET_RD,
    OP_SET_WR, OP_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic heap_wr;
    logic clr_last;
    logic in_acc;
    logic in_kind;
    logic prep_fail;
    logic scan_hit;
    logic scan_last;
    logic split_done;
    logic fchk1_fail;
    logic fchk2_fail;
    logic merge_more;
    logic merge_hit;
    logic out_free;
  } sts_t;

  // number of usable levels for a given heap size
  function automatic logic [5:0] active_levels_of(logic [HEAP_W-1:0] heap,
                                                 int min_l2, int top);
    logic [5:0] lg;
    logic [5:0] a;
    lg = '0;
    a  = '0;
    for (int i = 0; i < HEAP_W; i++) begin
      if (heap[i]) lg = 6'(i);
    end
    if (heap != '0 && lg >= 6'(min_l2)) begin
      a = lg - 6'(min_l2) + 6'd1;
      if (a > 6'(top + 1)) a = 6'(top + 1);
    end
    return a;
  endfunction

endpackage

>>> src/bba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram
// Single-port RAM, registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

>>> src/bba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: steps the datapath through clear, allocate and free flows.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd
);

  typedef enum logic [15:0] {
    S_CLR      = 16'h0001,
    S_TOPW     = 16'h0002,
    S_IDLE     = 16'h0004,
    S_PREP     = 16'h0008,
    S_SCAN_RD  = 16'h0010,
    S_SCAN_CHK = 16'h0020,
    S_SPLIT_RD = 16'h0040,
    S_SPLIT_WR = 16'h0080,
    S_TAG      = 16'h0100,
    S_FCHK1    = 16'h0200,
    S_FCHK2    = 16'h0400,
    S_MRD      = 16'h0800,
    S_MCHK     = 16'h1000,
    S_SET_RD   = 16'h2000,
    S_SET_WR   = 16'h4000,
    S_FIN      = 16'h8000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLR:      if (sts.clr_last) state_next = S_TOPW;
      S_TOPW:     state_next = S_IDLE;
      S_IDLE: begin
        if (sts.in_acc) begin
          state_next = (sts.in_kind == bba_pkg::KIND_FREE) ? S_FCHK1 : S_PREP;
        end
      end
      S_PREP:     state_next = sts.prep_fail ? S_FIN : S_SCAN_RD;
      S_SCAN_RD:  state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (sts.scan_hit) state_next = S_SPLIT_RD;
        else if (sts.scan_last) state_next = S_FIN;
        else state_next = S_SCAN_RD;
      end
      S_SPLIT_RD: state_next = sts.split_done ? S_TAG : S_SPLIT_WR;
      S_SPLIT_WR: state_next = S_SPLIT_RD;
      S_TAG:      state_next = S_FIN;
      S_FCHK1:    state_next = sts.fchk1_fail ? S_FIN : S_FCHK2;
      S_FCHK2:    state_next = sts.fchk2_fail ? S_FIN : S_MRD;
      S_MRD:      state_next = sts.merge_more ? S_MCHK : S_SET_RD;
      S_MCHK:     state_next = sts.merge_hit ? S_MRD : S_SET_RD;
      S_SET_RD:   state_next = S_SET_WR;
      S_SET_WR:   state_next = S_FIN;
      S_FIN:      if (sts.out_free) state_next = S_IDLE;
      default:    state_next = S_CLR;
    endcase
    // a heap resize restarts the clearing pass
    if (sts.heap_wr) state_next = S_CLR;
  end

  always_comb begin
    case (state)
      S_CLR:      cmd.op = bba_pkg::OP_CLR;
      S_TOPW:     cmd.op = bba_pkg::OP_TOPW;
      S_IDLE:     cmd.op = bba_pkg::OP_IDLE;
      S_PREP:     cmd.op = bba_pkg::OP_PREP;
      S_SCAN_RD:  cmd.op = bba_pkg::OP_SCAN_RD;
      S_SCAN_CHK: cmd.op = bba_pkg::OP_SCAN_CHK;
      S_SPLIT_RD: cmd.op = bba_pkg::OP_SPLIT_RD;
      S_SPLIT_WR: cmd.op = bba_pkg::OP_SPLIT_WR;
      S_TAG:      cmd.op = bba_pkg::OP_TAG;
      S_FCHK1:    cmd.op = bba_pkg::OP_FCHK1;
      S_FCHK2:    cmd.op = bba_pkg::OP_FCHK2;
      S_MRD:      cmd.op = bba_pkg::OP_MRD;
      S_MCHK:     cmd.op = bba_pkg::OP_MCHK;
      S_SET_RD:   cmd.op = bba_pkg::OP_SET_RD;
      S_SET_WR:   cmd.op = bba_pkg::OP_SET_WR;
      S_FIN:      cmd.op = bba_pkg::OP_FIN;
      default:    cmd.op = bba_pkg::OP_CLR;
    endcase
  end

endmodule

>>> src/bba_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: config registers, free-bit and tag memories, level counters,
// request registers and the output register.
// ----------------------------------------------------------------------------
module bba_dp #(
  parameter int MIN_BLOCK_LOG2 = bba_pkg::MIN_BLOCK_LOG2,
  parameter int HEAP_LOG2      = bba_pkg::HEAP_LOG2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bba_pkg::cmd_t                 cmd,
  output bba_pkg::sts_t                 sts,
  input  logic                          cfg_wr,
  input  logic                          cfg_idx,
  input  logic [bba_pkg::APB_DW-1:0]    cfg_wdata,
  output logic [bba_pkg::HEAP_W-1:0]    heap_bytes,
  output logic [bba_pkg::HDR_W-1:0]     header_bytes,
  input  logic                          in_valid,
  input  bba_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bba_pkg::out_t                 out_data
);

  localparam int TOP    = HEAP_LOG2 - MIN_BLOCK_LOG2;
  localparam int NL2    = TOP + 1;
  localparam int NB     = (NL2 > 6) ? NL2 : 6;      // node number width
  localparam int FAW    = NB - 5;                    // free-bit word address
  localparam int TAW    = (TOP > 0) ? TOP : 1;       // tag address / index
  localparam int SWL    = (TAW > FAW) ? TAW : FAW;   // clear sweep counter
  localparam int LVW    = $clog2(TOP + 2);
  localparam int LDEPTH = 1 << LVW;
  localparam int LEVELS = TOP + 1;
  localparam int CW     = TOP + 1;
  localparam int OFFB   = HEAP_LOG2;

  function automatic logic [NB-1:0] node_of(logic [LVW-1:0] l, logic [TAW-1:0] i);
    return (NB'(1) << (LVW'(TOP) - l)) + NB'(i);
  endfunction

  // registers
  logic [LVW-1:0]  active;
  logic [CW-1:0]   cnt [LDEPTH];
  logic [SWL-1:0]  clr_cnt;
  bba_pkg::in_t    in_r;
  logic [32:0]     need;
  logic [LVW-1:0]  want;
  logic [LVW-1:0]  lvl;
  logic [TAW-1:0]  idx;
  logic [FAW-1:0]  scan_addr;
  logic [FAW:0]    scan_left;
  logic [NB-1:0]   scan_base;
  logic [31:0]     smask;
  logic [NB-1:0]   tnode;
  bba_pkg::out_t   res;

  // memory ports
  logic             f_we, t_we;
  logic [FAW-1:0]   f_addr;
  logic [TAW-1:0]   t_addr;
  logic [31:0]      f_wdata, f_rdata;
  logic [bba_pkg::TAG_W-1:0] t_wdata, t_rdata;

  bba_ram #(.WIDTH(32), .DEPTH(1 << FAW)) u_free_ram (
    .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata)
  );

  bba_ram #(.WIDTH(bba_pkg::TAG_W), .DEPTH(1 << TAW)) u_tag_ram (
    .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata)
  );

  // allocate setup
  logic [32:0]    need_m1;
  logic [5:0]     bl, want_c;
  logic           fnd;
  logic [LVW-1:0] fl;
  logic [NB:0]    cntv;
  logic [NB-1:0]  p_base;
  logic           prep_fail;

  always_comb begin
    need_m1 = need - 33'd1;
    bl = '0;
    for (int i = 0; i < 33; i++) begin
      if (need_m1[i]) bl = 6'(i + 1);
    end
    want_c = (bl <= 6'(MIN_BLOCK_LOG2)) ? 6'd0 : bl - 6'(MIN_BLOCK_LOG2);
    fnd = 1'b0;
    fl  = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (!fnd && 6'(l) >= want_c && LVW'(l) < active && cnt[l] != '0) begin
        fnd = 1'b1;
        fl  = LVW'(l);
      end
    end
    prep_fail = (need == '0) || (want_c >= 6'(active)) || !fnd;
    cntv   = (NB + 1)'(1) << (active - LVW'(1) - fl);
    p_base = node_of(fl, '0);
  end

  // scan hit
  logic [31:0]    hitv;
  logic [4:0]     hp;
  logic           hit;
  logic [NB-1:0]  hnode;

  always_comb begin
    hitv = f_rdata & smask;
    hp = '0;
    for (int i = 31; i >= 0; i--) begin
      if (hitv[i]) hp = 5'(i);
    end
    hit   = |hitv;
    hnode = {scan_addr, hp};
  end

  // free checks
  logic [31:0]               off32;
  logic [5:0]                lim_sh, sh2;
  logic                      fail1, fail2;
  logic [bba_pkg::TAG_W-1:0] tl;

  always_comb begin
    off32  = 32'(in_r.block_offset);
    lim_sh = 6'(MIN_BLOCK_LOG2) + 6'(active) - 6'd1;
    fail1  = (active == '0) || (off32[MIN_BLOCK_LOG2-1:0] != '0) ||
             ((off32 >> lim_sh) != '0);
    tl     = t_rdata - bba_pkg::TAG_W'(1);
    sh2    = 6'(MIN_BLOCK_LOG2) + 6'(tl);
    fail2  = (t_rdata == '0) || (6'(t_rdata) > 6'(active)) ||
             ((off32 & ((32'(1) << sh2) - 32'd1)) != '0);
  end

  // node addressing for the read-modify-write steps
  logic [NB-1:0]  tn_split, tn_merge, tn_set, tn_top;
  logic [OFFB-1:0] a_off;
  logic            out_free;

  always_comb begin
    tn_split = node_of(lvl - LVW'(1), TAW'({idx, 1'b1}));
    tn_merge = node_of(lvl, idx ^ TAW'(1));
    tn_set   = node_of(lvl, idx);
    tn_top   = node_of(active - LVW'(1), '0);
    a_off    = (OFFB'(idx) << want) << MIN_BLOCK_LOG2;
    out_free = !out_valid || out_ready;
  end

  always_comb begin
    f_we    = 1'b0;
    f_addr  = scan_addr;
    f_wdata = f_rdata;
    t_we    = 1'b0;
    t_addr  = TAW'(off32 >> MIN_BLOCK_LOG2);
    t_wdata = '0;
    case (cmd.op)
      bba_pkg::OP_CLR: begin
        f_we    = 1'b1;
        f_addr  = clr_cnt[FAW-1:0];
        f_wdata = '0;
        t_we    = 1'b1;
        t_addr  = clr_cnt[TAW-1:0];
      end
      bba_pkg::OP_TOPW: begin
        f_we    = (active != '0);
        f_addr  = tn_top[NB-1:5];
        f_wdata = 32'(1) << tn_top[4:0];
      end
      bba_pkg::OP_SCAN_CHK: begin
        f_we    = hit;
        f_wdata = f_rdata & ~(32'(1) << hp);
      end
      bba_pkg::OP_SPLIT_RD: f_addr = tn_split[NB-1:5];
      bba_pkg::OP_SPLIT_WR: begin
        f_we    = 1'b1;
        f_addr  = tnode[NB-1:5];
        f_wdata = f_rdata | (32'(1) << tnode[4:0]);
      end
      bba_pkg::OP_TAG: begin
        t_we    = 1'b1;
        t_addr  = TAW'(idx << want);
        t_wdata = bba_pkg::TAG_W'(want) + bba_pkg::TAG_W'(1);
      end
      bba_pkg::OP_FCHK2: t_we = !fail2;
      bba_pkg::OP_MRD: f_addr = tn_merge[NB-1:5];
      bba_pkg::OP_MCHK: begin
        f_addr  = tnode[NB-1:5];
        f_we    = f_rdata[tnode[4:0]];
        f_wdata = f_rdata & ~(32'(1) << tnode[4:0]);
      end
      bba_pkg::OP_SET_RD: f_addr = tn_set[NB-1:5];
      bba_pkg::OP_SET_WR: begin
        f_we    = 1'b1;
        f_addr  = tnode[NB-1:5];
        f_wdata = f_rdata | (32'(1) << tnode[4:0]);
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.heap_wr    = cfg_wr && (cfg_idx == bba_pkg::REG_HEAP);
    sts.clr_last   = (clr_cnt == '1);
    sts.in_acc     = (cmd.op == bba_pkg::OP_IDLE) && in_valid;
    sts.in_kind    = in_data.kind;
    sts.prep_fail  = prep_fail;
    sts.scan_hit   = hit;
    sts.scan_last  = (scan_left == (FAW + 1)'(1));
    sts.split_done = (lvl == want);
    sts.fchk1_fail = fail1;
    sts.fchk2_fail = fail2;
    sts.merge_more = ((6'(lvl) + 6'd1) < 6'(active));
    sts.merge_hit  = f_rdata[tnode[4:0]];
    sts.out_free   = out_free;
  end

  logic [5:0] act_new;
  always_comb begin
    act_new = bba_pkg::active_levels_of(
        rst ? bba_pkg::HEAP_RESET : cfg_wdata[bba_pkg::HEAP_W-1:0],
        MIN_BLOCK_LOG2, TOP);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst || sts.heap_wr) begin
      if (rst) begin
        heap_bytes   <= bba_pkg::HEAP_RESET;
        header_bytes <= bba_pkg::HDR_RESET;
        out_valid    <= 1'b0;
      end else begin
        heap_bytes   <= cfg_wdata[bba_pkg::HEAP_W-1:0];
      end
      active  <= LVW'(act_new);
      clr_cnt <= '0;
      for (int l = 0; l < LDEPTH; l++) begin
        cnt[l] <= (act_new != '0 && 6'(l) == act_new - 6'd1) ? CW'(1) : '0;
      end
    end else begin
      if (cfg_wr && cfg_idx == bba_pkg::REG_HDR) begin
        header_bytes <= cfg_wdata[bba_pkg::HDR_W-1:0];
      end
      if (cmd.op == bba_pkg::OP_CLR) clr_cnt <= clr_cnt + SWL'(1);
      if (cmd.op == bba_pkg::OP_SCAN_CHK && hit) cnt[lvl] <= cnt[lvl] - CW'(1);
      if (cmd.op == bba_pkg::OP_MCHK && f_rdata[tnode[4:0]]) begin
        cnt[lvl] <= cnt[lvl] - CW'(1);
      end
      if (cmd.op == bba_pkg::OP_SPLIT_WR || cmd.op == bba_pkg::OP_SET_WR) begin
        cnt[lvl] <= cnt[lvl] + CW'(1);
      end
      if (cmd.op == bba_pkg::OP_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      bba_pkg::OP_IDLE: begin
        in_r <= in_data;
        need <= 33'(in_data.request_bytes) + 33'(header_bytes);
        res.status <= (in_data.kind == bba_pkg::KIND_FREE) ? bba_pkg::ST_BADFREE
                                                           : bba_pkg::ST_NOSPACE;
        res.granted_offset <= '0;
        res.granted_level  <= '0;
      end
      bba_pkg::OP_PREP: begin
        want      <= LVW'(want_c);
        lvl       <= fl;
        scan_base <= p_base;
        scan_addr <= p_base[NB-1:5];
        scan_left <= (cntv >= (NB + 1)'(32)) ? (FAW + 1)'(cntv >> 5) : (FAW + 1)'(1);
        smask     <= (cntv >= (NB + 1)'(32)) ? '1
                     : ((32'(1) << cntv[4:0]) - 32'd1) << p_base[4:0];
      end
      bba_pkg::OP_SCAN_CHK: begin
        if (hit) begin
          idx <= TAW'(hnode - scan_base);
        end else begin
          scan_addr <= scan_addr + FAW'(1);
          scan_left <= scan_left - (FAW + 1)'(1);
        end
      end
      bba_pkg::OP_SPLIT_RD: begin
        if (lvl != want) begin
          lvl   <= lvl - LVW'(1);
          idx   <= TAW'({idx, 1'b0});
          tnode <= tn_split;
        end
      end
      bba_pkg::OP_TAG: begin
        res.status         <= bba_pkg::ST_ALLOC;
        res.granted_offset <= bba_pkg::OFF_W'(a_off);
        res.granted_level  <= bba_pkg::GLVL_W'(want);
      end
      bba_pkg::OP_FCHK2: begin
        lvl <= LVW'(tl);
        idx <= TAW'(off32 >> sh2);
        if (!fail2) begin
          res.status         <= bba_pkg::ST_FREED;
          res.granted_offset <= in_r.block_offset;
          res.granted_level  <= bba_pkg::GLVL_W'(tl);
        end
      end
      bba_pkg::OP_MRD:    tnode <= tn_merge;
      bba_pkg::OP_MCHK: begin
        if (f_rdata[tnode[4:0]]) begin
          idx <= idx >> 1;
          lvl <= lvl + LVW'(1);
        end
      end
      bba_pkg::OP_SET_RD: tnode <= tn_set;
      bba_pkg::OP_FIN:    if (out_free) out_data <= res;
      default: ;
    endcase
  end

endmodule

>>> src/buddy_block_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// Binary buddy allocator: allocate and free requests in, one result out each.
// ----------------------------------------------------------------------------
//
//  port group   dir  handshake            payload
//  in_*         in   in_valid/in_ready    bba_pkg::in_t  (kind, bytes, offset)
//  out_*        out  out_valid/out_ready  bba_pkg::out_t (status, offset, lvl)
//  p*           in   APB write/read       heap_bytes @0x0, header_bytes @0x4
//
// One request at a time. Allocate: setup, a read and a check of each 32-bit
// free-map word scanned in the chosen level, a read and a write per level
// split, then the tag write; free: two checks, a buddy read and check per
// merge level tried, then a set read and write. The scan, split, merge and
// set steps are read-modify-writes on the single-port free-map RAM.
// Reset, and every heap_bytes write, start a clearing pass over both RAMs;
// no request is taken meanwhile. A finished result sits in the output
// register, so the next request is taken while it waits; a stalled output
// holds the block only at the final step.
//
module buddy_block_allocator_top #(
  parameter int MIN_BLOCK_LOG2 = bba_pkg::MIN_BLOCK_LOG2,
  parameter int HEAP_LOG2      = bba_pkg::HEAP_LOG2
) (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bba_pkg::in_t                in_data,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output bba_pkg::out_t               out_data,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bba_pkg::APB_AW-1:0]  paddr,
  input  logic [bba_pkg::APB_DW-1:0]  pwdata,
  output logic [bba_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  logic                       cfg_wr;
  logic                       cfg_idx;
  logic [bba_pkg::HEAP_W-1:0] heap_bytes;
  logic [bba_pkg::HDR_W-1:0]  header_bytes;

  // registers sit on 4-byte boundaries; bit 2 picks one
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[2];
  assign prdata  = (cfg_idx == bba_pkg::REG_HDR) ? bba_pkg::APB_DW'(header_bytes)
                                                 : bba_pkg::APB_DW'(heap_bytes);

  // requests are taken only while the sequencer waits for work
  assign in_ready = (cmd.op == bba_pkg::OP_IDLE);

  bba_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  bba_dp #(
    .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2),
    .HEAP_LOG2      (HEAP_LOG2)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_wr       (cfg_wr),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (pwdata),
    .heap_bytes   (heap_bytes),
    .header_bytes (header_bytes),
    .in_valid     (in_valid),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

>>> test/bba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker
// Watches the request, result and configuration ports of the buddy block
// allocator, predicts every result from its own copy of the heap tree and
// compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module bba_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  bba_pkg::in_t                 in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  bba_pkg::out_t                out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [bba_pkg::APB_AW-1:0]   paddr,
  input  logic [bba_pkg::APB_DW-1:0]   pwdata,
  output int                           errors,
  output int                           pending,
  output int                           results_seen
);

  localparam int MBL     = bba_pkg::MIN_BLOCK_LOG2;
  localparam int TOP_LVL = bba_pkg::HEAP_LOG2 - bba_pkg::MIN_BLOCK_LOG2;
  localparam int LEAVES  = 1 << TOP_LVL;
  localparam int NODES   = 2 << TOP_LVL;

  bit                          node_free [0:NODES-1];
  logic [bba_pkg::TAG_W-1:0]   slot_tag [0:LEAVES-1];
  int unsigned                 lvl_free_cnt [0:TOP_LVL];
  int unsigned                 live_levels;
  logic [bba_pkg::HEAP_W-1:0]  heap_cfg;
  logic [bba_pkg::HDR_W-1:0]   hdr_size;
  bba_pkg::out_t               expected_results [$];

  function automatic int unsigned node_idx(int unsigned l, int unsigned i);
    return ((32'd1 << (TOP_LVL - l)) + i) & (NODES - 1);
  endfunction

  task automatic rebuild_heap();
    int unsigned lg;
    lg = 0;
    for (int i = 0; i < NODES; i++) node_free[i] = 1'b0;
    for (int i = 0; i < LEAVES; i++) slot_tag[i] = '0;
    for (int i = 0; i <= TOP_LVL; i++) lvl_free_cnt[i] = 0;
    live_levels = 0;
    for (int i = 0; i < bba_pkg::HEAP_W; i++) if (heap_cfg[i]) lg = i;
    if (heap_cfg != '0 && lg >= MBL) begin
      live_levels = lg - MBL + 1;
      if (live_levels > TOP_LVL + 1) live_levels = TOP_LVL + 1;
      node_free[node_idx(live_levels - 1, 0)] = 1'b1;
      lvl_free_cnt[live_levels - 1] = 1;
    end
  endtask

  function automatic bba_pkg::out_t predict_alloc(logic [bba_pkg::REQ_W-1:0] req);
    longint unsigned need;
    int unsigned want, l, idx, cnt, off;
    bit hit;
    bba_pkg::out_t r;
    r = '{status: bba_pkg::ST_NOSPACE, granted_offset: '0, granted_level: '0};
    need = longint'(req) + longint'(hdr_size);
    want = 0;
    idx  = 0;
    hit  = 1'b0;
    if (need == 0) return r;
    while (want < 40 && (64'd1 << (MBL + want)) < need) want++;
    if (want >= live_levels) return r;
    l = want;
    while (l < live_levels && lvl_free_cnt[l] == 0) l++;
    if (l >= live_levels) return r;
    // lowest address free block in the level
    cnt = 32'd1 << (live_levels - 1 - l);
    for (int unsigned i = 0; i < cnt && !hit; i++) begin
      if (node_free[node_idx(l, i)]) begin
        idx = i;
        hit = 1'b1;
      end
    end
    if (!hit) return r;
    node_free[node_idx(l, idx)] = 1'b0;
    lvl_free_cnt[l]--;
    while (l > want) begin
      l--;
      idx = idx << 1;
      node_free[node_idx(l, idx + 1)] = 1'b1;
      lvl_free_cnt[l]++;
    end
    off = idx << (MBL + want);
    slot_tag[(off >> MBL) & (LEAVES - 1)] = bba_pkg::TAG_W'(want + 1);
    r.status         = bba_pkg::ST_ALLOC;
    r.granted_offset = bba_pkg::OFF_W'(off);
    r.granted_level  = bba_pkg::GLVL_W'(want);
    return r;
  endfunction

  function automatic bba_pkg::out_t predict_free(logic [bba_pkg::OFF_W-1:0] offset);
    int unsigned slot, tag, l, idx;
    bba_pkg::out_t r;
    r = '{status: bba_pkg::ST_BADFREE, granted_offset: '0, granted_level: '0};
    if (live_levels == 0) return r;
    if (offset & ((32'd1 << MBL) - 1)) return r;
    if (64'(offset) >= (64'd1 << (MBL + live_levels - 1))) return r;
    slot = (offset >> MBL) & (LEAVES - 1);
    tag  = slot_tag[slot];
    if (tag == 0 || tag > live_levels) return r;
    l = tag - 1;
    if (offset & ((32'd1 << (MBL + l)) - 1)) return r;
    slot_tag[slot] = '0;
    idx = offset >> (MBL + l);
    r.status         = bba_pkg::ST_FREED;
    r.granted_offset = offset;
    r.granted_level  = bba_pkg::GLVL_W'(l);
    // merge upward while the buddy is free at the same level
    while (l + 1 < live_levels && node_free[node_idx(l, idx ^ 1)]) begin
      node_free[node_idx(l, idx ^ 1)] = 1'b0;
      lvl_free_cnt[l]--;
      idx = idx >> 1;
      l++;
    end
    node_free[node_idx(l, idx)] = 1'b1;
    lvl_free_cnt[l]++;
    return r;
  endfunction

  task automatic report_mismatch(string what, bba_pkg::out_t got, bba_pkg::out_t want);
    $display("MISMATCH %s: got st=%0d off=%h lvl=%0d, want st=%0d off=%h lvl=%0d",
             what, got.status, got.granted_offset, got.granted_level,
             want.status, want.granted_offset, want.granted_level);
    errors++;
  endtask

  initial begin
    errors       = 0;
    pending      = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    bba_pkg::out_t want;
    if (rst) begin
      heap_cfg = bba_pkg::HEAP_RESET;
      hdr_size = bba_pkg::HDR_RESET;
      rebuild_heap();
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[bba_pkg::APB_AW-1:2] == bba_pkg::REG_HEAP) begin
          heap_cfg = pwdata[bba_pkg::HEAP_W-1:0];
          rebuild_heap();
        end else if (paddr[bba_pkg::APB_AW-1:2] == bba_pkg::REG_HDR) begin
          hdr_size = pwdata[bba_pkg::HDR_W-1:0];
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.kind == bba_pkg::KIND_ALLOC)
          expected_results.push_back(predict_alloc(in_data.request_bytes));
        else
          expected_results.push_back(predict_free(in_data.block_offset));
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_data, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", out_data, want);
          else if (out_data.granted_offset !== want.granted_offset)
            report_mismatch("granted_offset", out_data, want);
          else if (out_data.granted_level !== want.granted_level)
            report_mismatch("granted_level", out_data, want);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> test/tb_buddy_block_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator_top
// Drives allocate and free requests and configuration writes into the buddy
// allocator; the checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator_top;

  // Generous: seven clearing passes plus ~1650 requests, each at worst a full
  // level-0 scan plus stalls.
  localparam int CYCLE_LIMIT = 20000000;
  localparam int HOLD_CYCLES = 600;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  bba_pkg::in_t                  in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  bba_pkg::out_t                 out_data;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [bba_pkg::APB_AW-1:0]    paddr = '0;
  logic [bba_pkg::APB_DW-1:0]    pwdata = '0;
  logic [bba_pkg::APB_DW-1:0]    prdata;
  logic                          pready;

  int                            errors;
  int                            pending;
  int                            results_seen;
  int                            cycles = 0;
  int                            sent = 0;
  int                            heap_setups = 1;
  bit                            calm = 1'b0;      // no idling on either side
  bit                            hold_req = 1'b0;  // ask the receiver for one long hold-off
  int unsigned                   live_offsets [$]; // granted blocks not yet freed
  logic [bba_pkg::OFF_W-1:0]     last_freed = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  buddy_block_allocator_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  bba_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("buddy_block_allocator_top verification failed");
      $finish;
    end
  end

  // Result side: random stalls, a calm stretch, and one long hold-off that
  // backs the block up until in_ready drops.
  always @(posedge clk) begin
    static int hold_left = 0;
    static bit hold_done = 1'b0;
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 37);
    end
  end

  // Track granted blocks so most frees hit live allocations.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready && out_data.status == bba_pkg::ST_ALLOC)
      live_offsets.push_back(out_data.granted_offset);
  end

  // Offer one request; valid stays up until it is taken.
  task automatic push_request(logic kind, logic [bba_pkg::REQ_W-1:0] bytes,
                              logic [bba_pkg::OFF_W-1:0] off);
    bba_pkg::in_t r;
    r.kind          = kind;
    r.request_bytes = bytes;
    r.block_offset  = off;
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Let every outstanding result drain before touching the registers.
  // Wait on the clock first so the checker has logged the last request taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic apb_write(logic idx, logic [bba_pkg::APB_DW-1:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bba_pkg::APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == bba_pkg::REG_HEAP) begin
      // a heap write wipes the allocator, so forget every grant
      live_offsets.delete();
      heap_setups++;
    end
  endtask

  // Mostly allocations of small sizes and frees of live blocks, with double
  // frees and raw noise mixed in. Unused fields carry random bits.
  task automatic random_request();
    logic [bba_pkg::REQ_W-1:0] bytes;
    logic [bba_pkg::OFF_W-1:0] off;
    int p, k, pick;
    bytes = $urandom;
    off   = bba_pkg::OFF_W'($urandom);
    p     = $urandom_range(99);
    if (p < 50) begin
      k = $urandom_range(99);
      if (k < 70)      bytes = $urandom_range(0, 100);
      else if (k < 90) bytes = $urandom_range(0, 4000);
      else if (k < 97) bytes = $urandom_range(0, 300000);
      push_request(bba_pkg::KIND_ALLOC, bytes, off);
    end else if (p < 85) begin
      if (live_offsets.size() != 0) begin
        pick = $urandom_range(live_offsets.size() - 1);
        off  = bba_pkg::OFF_W'(live_offsets[pick]);
        live_offsets.delete(pick);
      end else begin
        off[bba_pkg::MIN_BLOCK_LOG2-1:0] = '0;
      end
      last_freed = off;
      push_request(bba_pkg::KIND_FREE, bytes, off);
    end else if (p < 92) begin
      push_request(bba_pkg::KIND_FREE, bytes, last_freed);
    end else begin
      push_request(bba_pkg::KIND_FREE, bytes, off);
    end
  endtask

  task automatic random_phase(int count, bit with_hold);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 20) hold_req = 1'b1;
      calm = (i >= count / 2 && i < count / 2 + 120);
      random_request();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Default heap 1 MiB, header 24: first grant lands at 0, level 1.
    push_request(bba_pkg::KIND_ALLOC, 32'd0, '0);
    push_request(bba_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 20'hFFFFF);   // too large
    push_request(bba_pkg::KIND_ALLOC, 32'd1048552, '0);           // whole heap, now busy
    push_request(bba_pkg::KIND_FREE,  32'hFFFF_FFFF, 20'd8);      // misaligned
    push_request(bba_pkg::KIND_FREE,  32'd0, 20'd0);              // good free
    push_request(bba_pkg::KIND_FREE,  32'd0, 20'd0);              // double free
    push_request(bba_pkg::KIND_FREE,  32'd0, 20'hFFFF0);          // never allocated
    push_request(bba_pkg::KIND_ALLOC, 32'd1048552, '0);           // whole heap fits
    push_request(bba_pkg::KIND_FREE,  32'd0, 20'd0);

    // No header: a zero-byte request is refused, small sizes hit level 0.
    apb_write(bba_pkg::REG_HDR, 32'd0);
    push_request(bba_pkg::KIND_ALLOC, 32'd0, '0);
    push_request(bba_pkg::KIND_ALLOC, 32'd1, '0);
    push_request(bba_pkg::KIND_ALLOC, 32'd16, '0);
    push_request(bba_pkg::KIND_ALLOC, 32'd17, '0);
    push_request(bba_pkg::KIND_FREE,  32'd0, 20'd16);
    push_request(bba_pkg::KIND_FREE,  32'd0, 20'd0);
    push_request(bba_pkg::KIND_FREE,  32'd0, 20'd32);

    // Smallest legal heap: one 16-byte block.
    apb_write(bba_pkg::REG_HEAP, 32'd16);
    push_request(bba_pkg::KIND_ALLOC, 32'd16, '0);
    push_request(bba_pkg::KIND_ALLOC, 32'd1, '0);                 // no space
    push_request(bba_pkg::KIND_FREE,  32'd0, 20'd16);             // outside the heap
    push_request(bba_pkg::KIND_FREE,  32'd0, 20'd0);

    // Heap below one block: nothing allocates, nothing frees.
    apb_write(bba_pkg::REG_HEAP, 32'd8);
    push_request(bba_pkg::KIND_ALLOC, 32'd1, '0);
    push_request(bba_pkg::KIND_FREE,  32'd0, 20'd0);

    // Non power of two heap, 64-byte header.
    apb_write(bba_pkg::REG_HEAP, 32'd1000);
    apb_write(bba_pkg::REG_HDR, 32'd64);
    push_request(bba_pkg::KIND_ALLOC, 32'd448, '0);
    push_request(bba_pkg::KIND_ALLOC, 32'd449, '0);               // too large for 512

    // Random traffic over a few heap and header settings.
    apb_write(bba_pkg::REG_HEAP, 32'd1048576);
    random_phase(500, 1'b1);
    apb_write(bba_pkg::REG_HDR, $urandom_range(0, 64));
    random_phase(300, 1'b0);
    apb_write(bba_pkg::REG_HEAP, 32'd4096);
    apb_write(bba_pkg::REG_HDR, 32'd0);
    random_phase(400, 1'b0);
    apb_write(bba_pkg::REG_HEAP, 32'h1F_FFFF);                    // clamps to top level
    apb_write(bba_pkg::REG_HDR, $urandom_range(0, 64));
    random_phase(450, 1'b0);

    drain();
    $display("covered %0d requests and %0d results over %0d heap setups,",
             sent, results_seen, heap_setups);
    $display("including a %0d-cycle result hold-off", HOLD_CYCLES);
    if (errors == 0) begin
      $display("buddy_block_allocator_top verification clean");
    end else begin
      $display("buddy_block_allocator_top verification failed");
    end
    $finish;
  end

endmodule

>>> buddy_block_allocator_top.f
src/bba_pkg.sv
src/bba_ram.sv
src/bba_ctrl.sv
src/bba_dp.sv
src/buddy_block_allocator_top.sv
test/bba_checker.sv
test/tb_buddy_block_allocator_top.sv
